// ===== hdl/conv1d_same_pad_layer_unit_macros.svh =====
// Assertion macros shared by the convolution layer RTL.
`ifndef CONV1D_SAME_PAD_LAYER_UNIT_MACROS_SVH
`define CONV1D_SAME_PAD_LAYER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define C1D_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define C1D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define C1D_ASSERT(lbl, clk, rst, prop, msg)
`define C1D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/c1d_pkg.sv =====
// Types and constants shared by the convolution layer modules.
`default_nettype none

package c1d_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAN_W = 5;
  localparam int TAP_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 16;
  localparam int RES_W = 16;
  localparam int PROD_W = 2 * VAL_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_CFG_W = 9;
  localparam int NCH_CFG_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_IN_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELU_ENABLE = 2'd2;

  localparam logic [LEN_CFG_W-1:0] SIGNAL_LENGTH_RST = 9'd92;
  localparam logic [NCH_CFG_W-1:0] ACTIVE_IN_CHANNELS_RST = 6'd32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_t;

  typedef struct packed {
    logic w_we;
    logic x_we;
    logic lane_ok;
  } c1d_lane_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/c1d_req_if.sv =====
// Request channel: weight, bias and sample writes and compute requests.
`default_nettype none

interface c1d_req_if
  import c1d_pkg::*;
;
  logic valid;
  logic ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAN_W-1:0] out_chan;
  logic [CHAN_W-1:0] in_chan;
  logic [TAP_W-1:0] tap;
  logic [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, opcode, out_chan, in_chan, tap, position, value,
                  input ready);
  modport sink (input valid, opcode, out_chan, in_chan, tap, position, value,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/c1d_rsp_if.sv =====
// Result channel: one output feature value per compute request.
`default_nettype none

interface c1d_rsp_if
  import c1d_pkg::*;
;
  logic valid;
  logic ready;
  logic signed [RES_W-1:0] result;
  logic [CHAN_W-1:0] result_chan;
  logic [POS_W-1:0] result_pos;

  modport source (output valid, result, result_chan, result_pos, input ready);
  modport sink (input valid, result, result_chan, result_pos, output ready);
endinterface

`default_nettype wire

// ===== hdl/c1d_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface c1d_cfg_if
  import c1d_pkg::*;
;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/c1d_lane.sv =====
// One kernel tap lane: weight and shifted sample memories and a registered product.
`default_nettype none

module c1d_lane
  import c1d_pkg::*;
#(
  parameter int CH_W = 5,
  parameter int QW = 9
) (
  input  logic                       clk,
  input  c1d_lane_ctl_t              ctl,
  input  logic [2*CH_W-1:0]          w_waddr,
  input  logic [2*CH_W-1:0]          w_raddr,
  input  logic [CH_W+QW-1:0]         x_waddr,
  input  logic [CH_W+QW-1:0]         x_raddr,
  input  logic signed [VAL_W-1:0]    wdata,
  output logic signed [PROD_W-1:0]   prod
);

  // Each sample is stored at the output position whose window sees it in this lane.
  logic signed [VAL_W-1:0] w_mem [1 << (2 * CH_W)];
  logic signed [VAL_W-1:0] x_mem [1 << (CH_W + QW)];
  logic signed [VAL_W-1:0] w_rd;
  logic signed [VAL_W-1:0] x_rd;
  logic ok_rd;

  always_ff @(posedge clk) begin
    if (ctl.w_we) begin
      w_mem[w_waddr] <= wdata;
    end
    w_rd <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.x_we) begin
      x_mem[x_waddr] <= wdata;
    end
    x_rd <= x_mem[x_raddr];
  end

  always_ff @(posedge clk) begin
    ok_rd <= ctl.lane_ok;
    prod <= ok_rd ? PROD_W'(w_rd * x_rd) : '0;
  end

endmodule

`default_nettype wire

// ===== hdl/conv1d_same_pad_layer_unit.sv =====
// Top level of the 1D convolution layer with same padding, bias and optional ReLU.
// Usage: the req channel carries one opcode per transfer. Weight, bias and
// sample writes give no result. A compute request sums bias plus weight
// times sample over the active input channels, all kernel taps of one input
// channel in parallel, and returns one transfer on the rsp channel with the
// saturated value, channel and position.
// The active input channels pass one after another through the tap lane
// memories; the product register, the accumulator, the drain check and the
// output register follow. When no channel is active, the compute goes straight
// to the drain check. One request is worked on at a time; req is ready only
// while no compute is in flight, so a new request is taken only once the last
// compute has loaded its result into the output register.
// The result sits in an output register. A new request is taken while it
// waits; a stalled receiver holds only the final step of the next compute.
// Configuration writes on cfg are always taken and must happen while idle.
// Reset clears the control state and sets the registers to their defaults;
// the memories are not cleared and hold no meaning until written.
`default_nettype none
`include "conv1d_same_pad_layer_unit_macros.svh"

module conv1d_same_pad_layer_unit
  import c1d_pkg::*;
#(
  parameter int CHANNELS = 32,
  parameter int TAPS = 5,
  parameter int LEN_MAX = 256,
  parameter int DATA_W = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  c1d_req_if.sink      req,
  c1d_rsp_if.source    rsp,
  c1d_cfg_if.sink      cfg
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PAD = TAPS / 2;
  localparam int QW = $clog2(LEN_MAX + TAPS);
  localparam int NCH_W = $clog2(CHANNELS + 1);
  localparam int LENC_W = $clog2(LEN_MAX + 1);
  localparam int ACC_W = PROD_W + $clog2(CHANNELS * TAPS + 1) + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  logic [CH_W-1:0] ch;
  logic [NCH_W-1:0] nch_q;
  logic [CHAN_W-1:0] oc_q;
  logic [POS_W-1:0] pos_q;
  logic [TAPS-1:0] lane_ok_q;
  logic [TAPS-1:0] lane_ok_next;
  logic v_rd;
  logic v_prod;
  logic load_bias;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] y_shift;
  logic signed [ACC_W-1:0] y_sat;

  logic [LEN_CFG_W-1:0] signal_length;
  logic [NCH_CFG_W-1:0] active_in_channels;
  logic relu_enable;
  logic [LENC_W-1:0] len_clip;
  logic [NCH_W-1:0] nch_clip;

  logic signed [VAL_W-1:0] bias_mem [1 << CH_W];
  logic signed [VAL_W-1:0] bias_rd;

  logic req_fire;
  logic oc_ok;
  logic ic_ok;
  logic pos_ok;
  logic out_free;

  c1d_lane_ctl_t lane_ctl [TAPS];
  logic [CH_W+QW-1:0] x_waddr [TAPS];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic [2*CH_W-1:0] w_waddr;
  logic [2*CH_W-1:0] w_raddr;
  logic [CH_W+QW-1:0] x_raddr;

  logic out_valid;
  logic signed [RES_W-1:0] out_result;
  logic [CHAN_W-1:0] out_chan;
  logic [POS_W-1:0] out_pos;

  assign req.ready = (state == S_IDLE);
  assign req_fire = req.valid && req.ready;
  assign oc_ok = int'(req.out_chan) < CHANNELS;
  assign ic_ok = int'(req.in_chan) < CHANNELS;
  assign pos_ok = int'(req.position) < LEN_MAX;
  assign out_free = !out_valid || rsp.ready;

  assign len_clip = (int'(signal_length) > LEN_MAX) ? LENC_W'(LEN_MAX)
                                                     : LENC_W'(signal_length);
  assign nch_clip = (int'(active_in_channels) > CHANNELS) ? NCH_W'(CHANNELS)
                                                           : NCH_W'(active_in_channels);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_length <= SIGNAL_LENGTH_RST;
      active_in_channels <= ACTIVE_IN_CHANNELS_RST;
      relu_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SIGNAL_LENGTH: signal_length <= cfg.data[LEN_CFG_W-1:0];
        REG_ACTIVE_IN_CHANNELS: active_in_channels <= cfg.data[NCH_CFG_W-1:0];
        REG_RELU_ENABLE: relu_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign w_waddr = {CH_W'(req.out_chan), CH_W'(req.in_chan)};
  assign w_raddr = {CH_W'(oc_q), ch};
  assign x_raddr = {ch, QW'(pos_q)};

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      lane_ok_next[k] = (int'(req.position) + k >= PAD) &&
                        (int'(req.position) + k - PAD < int'(len_clip));
      lane_ctl[k].w_we = req_fire && (req.opcode == OP_WEIGHT) && oc_ok && ic_ok &&
                         (int'(req.tap) == k);
      lane_ctl[k].x_we = req_fire && (req.opcode == OP_SAMPLE) && ic_ok && pos_ok &&
                         (int'(req.position) + PAD >= k);
      lane_ctl[k].lane_ok = lane_ok_q[k];
      x_waddr[k] = {CH_W'(req.in_chan), QW'(int'(req.position) + PAD - k)};
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_lane
    c1d_lane #(
      .CH_W(CH_W),
      .QW(QW)
    ) u_lane (
      .clk(clk),
      .ctl(lane_ctl[k]),
      .w_waddr(w_waddr),
      .w_raddr(w_raddr),
      .x_waddr(x_waddr[k]),
      .x_raddr(x_raddr),
      .wdata(req.value),
      .prod(prod[k])
    );
  end

  always_ff @(posedge clk) begin
    if (req_fire && (req.opcode == OP_BIAS) && oc_ok) begin
      bias_mem[CH_W'(req.out_chan)] <= req.value;
    end
    bias_rd <= bias_mem[CH_W'(req.out_chan)];
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + ACC_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v_rd <= 1'b0;
      v_prod <= 1'b0;
      load_bias <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_rd <= (state == S_RUN);
      v_prod <= v_rd;
      load_bias <= req_fire && (req.opcode == OP_COMPUTE) && oc_ok;
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.opcode == OP_COMPUTE) && oc_ok) begin
            state <= (nch_clip == '0) ? S_DRAIN : S_RUN;
          end
        end
        S_RUN: begin
          if (int'(ch) + 1 >= int'(nch_q)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v_rd && !v_prod && !load_bias) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      oc_q <= req.out_chan;
      pos_q <= req.position;
      lane_ok_q <= lane_ok_next;
      nch_q <= nch_clip;
      ch <= '0;
    end else if (state == S_RUN) begin
      ch <= ch + CH_W'(1);
    end
    if (load_bias) begin
      acc <= ACC_W'(bias_rd) <<< FRAC_BITS;
    end else if (v_prod) begin
      acc <= acc + sum;
    end
  end

  assign y_shift = acc >>> FRAC_BITS;

  always_comb begin
    priority if (y_shift > SAT_MAX) begin
      y_sat = SAT_MAX;
    end else if (y_shift < SAT_MIN) begin
      y_sat = SAT_MIN;
    end else begin
      y_sat = y_shift;
    end
    if (relu_enable && y_sat[ACC_W-1]) begin
      y_sat = '0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_result <= y_sat[RES_W-1:0];
      out_chan <= oc_q;
      out_pos <= pos_q;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.result = out_result;
  assign rsp.result_chan = out_chan;
  assign rsp.result_pos = out_pos;

  `C1D_ASSERT(a_idle_pipe_empty, clk, rst, (req.ready |-> (!v_rd && !v_prod && !load_bias)), "request taken while a compute is in flight")
  `C1D_ASSERT(a_run_ch_range, clk, rst, ((state == S_RUN) |-> (int'(ch) < int'(nch_q))), "channel counter past the active channel count")
  `C1D_ASSERT_NEXT(a_done_delivers, clk, rst, ((state == S_DONE) && (!rsp.valid || rsp.ready)), (rsp.valid && (state == S_IDLE)), "finished compute did not load the output register")
  `C1D_ASSERT_NEXT(a_compute_starts, clk, rst, (req.valid && req.ready && (req.opcode == OP_COMPUTE) && oc_ok), (state != S_IDLE), "compute transfer did not start the sequence")

endmodule

`default_nettype wire

// ===== dv/tb_conv1d_same_pad_layer_unit.sv =====
// Testbench for the 1D convolution layer: directed and random requests checked against a scoreboard.
`timescale 1ns / 1ps

module tb_conv1d_same_pad_layer_unit;
  import c1d_pkg::*;

  localparam int CHANNELS = 32;
  localparam int TAPS = 5;
  localparam int LEN_MAX = 256;
  localparam int DATA_W = 16;
  localparam int FRAC_BITS = 8;
  localparam int PAD = TAPS / 2;
  localparam int W_DEPTH = CHANNELS * CHANNELS * TAPS;
  localparam int X_DEPTH = CHANNELS * LEN_MAX;
  localparam int SETTLE_CYCLES = CHANNELS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 9;

  typedef struct packed {
    opcode_t op;
    logic [CHAN_W-1:0] oc;
    logic [CHAN_W-1:0] ic;
    logic [TAP_W-1:0] tap;
    logic [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;
  } conv_req_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [CHAN_W-1:0] chan;
    logic [POS_W-1:0] pos;
  } feature_t;

  class feature_scoreboard;
    logic signed [VAL_W-1:0] weights [W_DEPTH];
    logic signed [VAL_W-1:0] biases [CHANNELS];
    logic signed [VAL_W-1:0] samples [X_DEPTH];
    bit weight_set [W_DEPTH];
    bit bias_set [CHANNELS];
    bit sample_set [X_DEPTH];
    int unsigned sig_len = SIGNAL_LENGTH_RST;
    int unsigned act_ch = ACTIVE_IN_CHANNELS_RST;
    bit relu_on;
    feature_t features_due [$];
    int errors, checked, writes, ignored, computes;

    function int w_index(int oc, int ic, int k);
      return (oc * CHANNELS + ic) * TAPS + k;
    endfunction

    function int x_index(int ic, int p);
      return ic * LEN_MAX + p;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SIGNAL_LENGTH: sig_len = data[LEN_CFG_W-1:0];
        REG_ACTIVE_IN_CHANNELS: act_ch = data[NCH_CFG_W-1:0];
        REG_RELU_ENABLE: relu_on = data[0];
        default: ;
      endcase
    endfunction

    function feature_t predict_feature(int oc, int pos);
      feature_t f;
      longint acc, y, sat_hi, sat_lo;
      int len, nch, p;
      len = (sig_len > LEN_MAX) ? LEN_MAX : int'(sig_len);
      nch = (act_ch > CHANNELS) ? CHANNELS : int'(act_ch);
      sat_hi = (longint'(1) << (DATA_W - 1)) - 1;
      sat_lo = -sat_hi - 1;
      acc = longint'(biases[oc]) * (longint'(1) << FRAC_BITS);
      for (int c = 0; c < nch; c++) begin
        for (int k = 0; k < TAPS; k++) begin
          p = pos + k - PAD;
          if (p >= 0 && p < len)
            acc += longint'(weights[w_index(oc, c, k)]) * longint'(samples[x_index(c, p)]);
        end
      end
      y = acc >>> FRAC_BITS;
      if (y > sat_hi) y = sat_hi;
      if (y < sat_lo) y = sat_lo;
      if (relu_on && y < 0) y = 0;
      f.result = y[RES_W-1:0];
      f.chan = CHAN_W'(oc);
      f.pos = POS_W'(pos);
      return f;
    endfunction

    function void note_request(conv_req_t it);
      case (it.op)
        OP_WEIGHT: begin
          if (it.tap < TAPS) begin
            weights[w_index(it.oc, it.ic, it.tap)] = it.val;
            weight_set[w_index(it.oc, it.ic, it.tap)] = 1'b1;
            writes++;
          end else begin
            ignored++;
          end
        end
        OP_BIAS: begin
          biases[it.oc] = it.val;
          bias_set[it.oc] = 1'b1;
          writes++;
        end
        OP_SAMPLE: begin
          samples[x_index(it.ic, it.pos)] = it.val;
          sample_set[x_index(it.ic, it.pos)] = 1'b1;
          writes++;
        end
        default: begin
          features_due.push_back(predict_feature(it.oc, it.pos));
          computes++;
        end
      endcase
    endfunction

    function void check_feature(feature_t got);
      feature_t want;
      if (features_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %0d chan %0d pos %0d",
                 $time, $signed(got.result), got.chan, got.pos);
        return;
      end
      want = features_due.pop_front();
      checked++;
      if (got.result !== want.result) begin
        errors++;
        $display("%0t: value mismatch at chan %0d pos %0d: expected %0d, actual %0d",
                 $time, want.chan, want.pos, $signed(want.result), $signed(got.result));
      end
      if (got.chan !== want.chan) begin
        errors++;
        $display("%0t: channel mismatch: expected %0d, actual %0d", $time, want.chan, got.chan);
      end
      if (got.pos !== want.pos) begin
        errors++;
        $display("%0t: position mismatch: expected %0d, actual %0d", $time, want.pos, got.pos);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  c1d_req_if req_if ();
  c1d_rsp_if rsp_if ();
  c1d_cfg_if cfg_if ();

  conv1d_same_pad_layer_unit #(
    .CHANNELS(CHANNELS),
    .TAPS(TAPS),
    .LEN_MAX(LEN_MAX),
    .DATA_W(DATA_W),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  feature_scoreboard sb = new;
  int n_sent;
  int burst_left;
  bit steady;
  int holds_wanted;
  int holds_done;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return VAL_W'($urandom_range(0, 1023) - 512);
    if (sel < 8) return VAL_W'($urandom_range(0, 65535));
    case (sel)
      8: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      default: return ($urandom_range(0, 1) == 1) ? 16'sh0000 : 16'shFFFF;
    endcase
  endfunction

  task automatic send_req(opcode_t op, int oc, int ic, int tap, int pos,
                          logic signed [VAL_W-1:0] val);
    conv_req_t it;
    it.op = op;
    it.oc = CHAN_W'(oc);
    it.ic = CHAN_W'(ic);
    it.tap = TAP_W'(tap);
    it.pos = POS_W'(pos);
    it.val = val;
    case (op)
      OP_WEIGHT: it.pos = POS_W'($urandom_range(0, 255));
      OP_BIAS: begin
        it.ic = CHAN_W'($urandom_range(0, 31));
        it.tap = TAP_W'($urandom_range(0, 7));
        it.pos = POS_W'($urandom_range(0, 255));
      end
      OP_SAMPLE: begin
        it.oc = CHAN_W'($urandom_range(0, 31));
        it.tap = TAP_W'($urandom_range(0, 7));
      end
      default: begin
        it.ic = CHAN_W'($urandom_range(0, 31));
        it.tap = TAP_W'($urandom_range(0, 7));
        it.val = VAL_W'($urandom_range(0, 65535));
      end
    endcase
    if (burst_left == 0) begin
      if (!steady) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.opcode <= it.op;
    req_if.out_chan <= it.oc;
    req_if.in_chan <= it.ic;
    req_if.tap <= it.tap;
    req_if.position <= it.pos;
    req_if.value <= it.val;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(it);
    n_sent++;
  endtask

  // Writes every weight, bias and sample a compute at this channel and position can touch,
  // including wrapped addresses next to the edges, unless already written.
  task automatic prime_inputs(int oc, int pos);
    int nch, p;
    nch = (sb.act_ch > CHANNELS) ? CHANNELS : int'(sb.act_ch);
    if (!sb.bias_set[oc]) send_req(OP_BIAS, oc, 0, 0, 0, pick_value());
    for (int c = 0; c < nch; c++) begin
      for (int k = 0; k < TAPS; k++) begin
        if (!sb.weight_set[sb.w_index(oc, c, k)]) send_req(OP_WEIGHT, oc, c, k, 0, pick_value());
        p = (pos + k - PAD) & (LEN_MAX - 1);
        if (!sb.sample_set[sb.x_index(c, p)]) send_req(OP_SAMPLE, 0, c, 0, p, pick_value());
      end
    end
  endtask

  task automatic compute_at(int oc, int pos);
    prime_inputs(oc, pos);
    send_req(OP_COMPUTE, oc, 0, 0, pos, '0);
  endtask

  task automatic random_compute();
    int oc, pos, len;
    bit wide;
    wide = sb.act_ch > 8;
    len = (sb.sig_len > LEN_MAX) ? LEN_MAX : int'(sb.sig_len);
    oc = (wide && $urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 5))
          0: pos = $urandom_range(0, 2);
          1: pos = len - 1;
          2: pos = len;
          3: pos = len + 1;
          4: pos = len - 2;
          default: pos = $urandom_range(253, 255);
        endcase
      end
      default: pos = wide ? $urandom_range(0, 11) : $urandom_range(0, 255);
    endcase
    compute_at(oc, pos & (LEN_MAX - 1));
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)
      random_compute();
    else if (sel < 58)
      send_req(OP_SAMPLE, 0, $urandom_range(0, 31), 0, $urandom_range(0, 255), pick_value());
    else if (sel < 80)
      send_req(OP_WEIGHT, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 4), 0,
               pick_value());
    else if (sel < 94)
      send_req(OP_BIAS, $urandom_range(0, 31), 0, 0, 0, pick_value());
    else
      send_req(OP_WEIGHT, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(5, 7), 0,
               pick_value());
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.features_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, CFG_DATA_W'(data));
  endtask

  task automatic set_layer(int len, int nch, int relu);
    cfg_write(REG_SIGNAL_LENGTH, len);
    cfg_write(REG_ACTIVE_IN_CHANNELS, nch);
    cfg_write(REG_RELU_ENABLE, relu);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : rsp_sink
    int mode, left, cyc;
    mode = 0;
    left = 0;
    cyc = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_wanted) begin
        holds_done++;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        cyc++;
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= (cyc % 7) < 4;
          default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    feature_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.result = rsp_if.result;
      got.chan = rsp_if.result_chan;
      got.pos = rsp_if.result_pos;
      sb.check_feature(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic signed [VAL_W-1:0] edge_vals [8] = '{16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF,
                                                16'sh0100, 16'shFF00, 16'sh3039, 16'shCFC7};
    int lens [PHASES] = '{1, 0, 256, 511, 300, 17, 92, 40, 0};
    int nchs [PHASES] = '{1, 4, 32, 2, 3, 63, 0, 33, 0};
    int relus [PHASES] = '{1, 0, 0, 1, 0, 1, 0, 1, 0};
    int phase_end, len, nch, relu;
    req_if.valid <= 1'b0;
    req_if.opcode <= OP_WEIGHT;
    req_if.out_chan <= '0;
    req_if.in_chan <= '0;
    req_if.tap <= '0;
    req_if.position <= '0;
    req_if.value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_SIGNAL_LENGTH;
    cfg_if.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_layer(8, 1, 0);
    send_req(OP_WEIGHT, 0, 0, 0, 0, 16'sh7FFF);
    send_req(OP_WEIGHT, 0, 0, 1, 0, 16'sh8000);
    send_req(OP_WEIGHT, 0, 0, 2, 0, 16'sh0000);
    send_req(OP_WEIGHT, 0, 0, 3, 0, 16'shFFFF);
    send_req(OP_WEIGHT, 0, 0, 4, 0, 16'sh0001);
    send_req(OP_WEIGHT, 0, 0, 7, 0, 16'sh7FFF);
    send_req(OP_WEIGHT, 0, 0, 5, 0, 16'sh8000);
    send_req(OP_BIAS, 0, 0, 0, 0, 16'sh7FFF);
    for (int p = 0; p < 8; p++) send_req(OP_SAMPLE, 0, 0, 0, p, edge_vals[p]);
    compute_at(0, 0);
    compute_at(0, 7);
    compute_at(0, 3);
    compute_at(0, 255);
    send_req(OP_BIAS, 0, 0, 0, 0, 16'sh8000);
    compute_at(0, 3);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      len = lens[ph];
      nch = nchs[ph];
      relu = relus[ph];
      if (ph == PHASES - 1) begin
        len = $urandom_range(1, 256);
        nch = $urandom_range(1, 8);
        relu = $urandom_range(0, 1);
      end
      set_layer(len, nch, relu);
      steady = ($urandom_range(0, 3) == 0);
      phase_end = n_sent + ((nch > 8) ? 260 : 180);
      if (ph == 0) begin
        // Long receiver stall while back-to-back computes pile up behind it.
        holds_wanted++;
        steady = 1'b1;
        repeat (16) random_compute();
        steady = 1'b0;
      end
      while (n_sent < phase_end) random_item();
      settle();
    end

    if (sb.features_due.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.features_due.size());
    end
    $display("Sent %0d requests: %0d writes, %0d ignored writes, %0d computes, %0d layer settings.",
             n_sent, sb.writes, sb.ignored, sb.computes, PHASES + 1);
    $display("Checked %0d results with %0d failures.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/c1d_pkg.sv
hdl/c1d_req_if.sv
hdl/c1d_rsp_if.sv
hdl/c1d_cfg_if.sv
hdl/c1d_lane.sv
hdl/conv1d_same_pad_layer_unit.sv
dv/tb_conv1d_same_pad_layer_unit.sv
